@@ design/debounced_press_duration_recorder_assert.svh @@
// Assertion helpers shared by the recorder modules.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef DEBOUNCED_PRESS_DURATION_RECORDER_ASSERT_SVH
`define DEBOUNCED_PRESS_DURATION_RECORDER_ASSERT_SVH

`ifndef SYNTHESIS

`define DPDR_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

`define DPDR_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define DPDR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define DPDR_ASSERT_ALWAYS(lbl, expr)
`define DPDR_ASSERT_IMPLY(lbl, ante, cons)
`define DPDR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ design/dpdr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dpdr_pkg;

  // Number of duration entries in the store.
  localparam int STORE_DEPTH = 16;
  localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int FILL_W      = $clog2(STORE_DEPTH + 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_EVENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT      = 2'd2;

  localparam logic [15:0] MIN_EVENT_RST = 16'd20;
  localparam logic [15:0] MAX_PRESS_RST = 16'd2000;
  localparam logic [15:0] WAIT_RST      = 16'd3000;

  typedef struct packed {
    logic [15:0] min_event_ms;
    logic [15:0] max_press_ms;
    logic [15:0] wait_ms;
  } cfg_t;

  typedef struct packed {
    logic        smooth_level;
    logic        error_flag;
    logic        finished_flag;
    logic        listening_flag;
    logic        stored_valid;
    logic [15:0] stored_duration;
    logic [4:0]  stored_count;
  } res_t;

  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
    logic [15:0]         data;
  } store_wr_t;

endpackage

`default_nettype wire

@@ design/dpdr_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Duration store. Entries are only appended; contents are undefined until written.
module dpdr_store (
  input  wire logic              clk,
  input  wire dpdr_pkg::store_wr_t wr
);

  logic [15:0] mem [dpdr_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

endmodule

`default_nettype wire

@@ design/dpdr_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "debounced_press_duration_recorder_assert.svh"

// Debounce, press timing and flag logic. One word is processed per accepted cycle.
module dpdr_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 acc,
  input  wire logic                 cmd,
  input  wire logic                 raw,
  input  wire logic [31:0]          now,
  input  wire dpdr_pkg::cfg_t       cfg,
  output dpdr_pkg::res_t            res,
  output dpdr_pkg::store_wr_t       wr
);

  logic                        level_r, level_nxt;
  logic [31:0]                 last_chg_r, last_chg_nxt;
  logic [31:0]                 ev_start_r, ev_start_nxt;
  logic                        err_r, err_nxt;
  logic                        fin_r, fin_nxt;
  logic                        lis_r, lis_nxt;
  logic [dpdr_pkg::FILL_W-1:0] fill_r, fill_nxt;

  logic [31:0]                 since_chg;
  logic [31:0]                 held;
  logic [15:0]                 held_sat;
  logic                        full;
  logic                        stored;
  logic [dpdr_pkg::FILL_W+4:0] fill_ext;

  assign since_chg = now - last_chg_r;
  assign held      = now - ev_start_r;
  assign held_sat  = (|held[31:16]) ? 16'hFFFF : held[15:0];
  assign full      = fill_r >= dpdr_pkg::FILL_W'(dpdr_pkg::STORE_DEPTH);

  always_comb begin
    level_nxt    = level_r;
    last_chg_nxt = last_chg_r;
    ev_start_nxt = ev_start_r;
    err_nxt      = err_r;
    fin_nxt      = fin_r;
    lis_nxt      = lis_r;
    fill_nxt     = fill_r;
    stored       = 1'b0;
    if (cmd) begin
      level_nxt = 1'b0;
      err_nxt   = 1'b0;
      fin_nxt   = 1'b0;
      lis_nxt   = 1'b0;
      fill_nxt  = '0;
    end else if (!err_r && !fin_r) begin
      // Every raw change restarts the debounce timer, taken or not.
      if (raw != level_r) begin
        last_chg_nxt = now;
        if (since_chg >= {16'd0, cfg.min_event_ms}) begin
          level_nxt = raw;
        end
      end
      if (level_r) begin
        if (level_nxt) begin
          if (held > {16'd0, cfg.max_press_ms}) begin
            err_nxt = 1'b1;
          end
        end else begin
          ev_start_nxt = now;
          if (full) begin
            err_nxt = 1'b1;
          end else begin
            stored   = 1'b1;
            fill_nxt = fill_r + 1'b1;
          end
        end
      end else if (level_nxt) begin
        ev_start_nxt = now;
        lis_nxt      = 1'b1;
      end else if (lis_r && (held > {16'd0, cfg.wait_ms})) begin
        if (full) begin
          fin_nxt = 1'b1;
        end else begin
          err_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= 1'b0;
      last_chg_r <= '0;
      ev_start_r <= '0;
      err_r      <= 1'b0;
      fin_r      <= 1'b0;
      lis_r      <= 1'b0;
      fill_r     <= '0;
    end else if (acc) begin
      level_r    <= level_nxt;
      last_chg_r <= last_chg_nxt;
      ev_start_r <= ev_start_nxt;
      err_r      <= err_nxt;
      fin_r      <= fin_nxt;
      lis_r      <= lis_nxt;
      fill_r     <= fill_nxt;
    end
  end

  assign fill_ext = {5'd0, fill_nxt};

  always_comb begin
    res.smooth_level    = level_nxt;
    res.error_flag      = err_nxt;
    res.finished_flag   = fin_nxt;
    res.listening_flag  = lis_nxt;
    res.stored_valid    = stored;
    res.stored_duration = stored ? held_sat : 16'd0;
    res.stored_count    = fill_ext[4:0];
  end

  assign wr.en   = acc && stored;
  assign wr.addr = fill_r[dpdr_pkg::STORE_AW-1:0];
  assign wr.data = held_sat;

  `DPDR_ASSERT_ALWAYS(a_fill_bound, fill_r <= dpdr_pkg::FILL_W'(dpdr_pkg::STORE_DEPTH))
  `DPDR_ASSERT_NEXT(a_store_advances, acc && stored, fill_r == $past(fill_r) + 1'b1)
  `DPDR_ASSERT_NEXT(a_err_sticky, err_r && acc && !cmd, err_r)

endmodule

`default_nettype wire

@@ design/dpdr_out_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "debounced_press_duration_recorder_assert.svh"

// Two-word result queue; it lets the input keep flowing during an output stall until both words are held.
module dpdr_out_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire dpdr_pkg::res_t push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output dpdr_pkg::res_t      head
);

  dpdr_pkg::res_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign head      = slot_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  `DPDR_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= 2'd2)
  `DPDR_ASSERT_IMPLY(a_no_push_full, push, !full)
  `DPDR_ASSERT_NEXT(a_pop_drains, do_pop && !push, cnt_r == $past(cnt_r) - 2'd1)

endmodule

`default_nettype wire

@@ design/debounced_press_duration_recorder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake            Payload
// in_      in_valid / in_stall  in_command, in_raw_level, in_now_ms
// out_     out_valid/ out_stall out_smooth_level .. out_stored_count
// cfg_     cfg_valid/ cfg_ready cfg_index, cfg_data
//
// One word is accepted per clock cycle while the output queue has room; its result enters
// the queue at the same edge and can leave on the next cycle.
// The rate is set by the registered update of the debounce state and the store write port.
// Reset is synchronous and active low; it restores the register defaults and clears all flags.
// The two-word output queue absorbs a stall; in_stall rises only when both words are waiting.
// The configuration port is always ready and should be written only while the block is idle.
module debounced_press_duration_recorder (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic        in_raw_level,
  input  wire logic [31:0] in_now_ms,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_smooth_level,
  output logic             out_error_flag,
  output logic             out_finished_flag,
  output logic             out_listening_flag,
  output logic             out_stored_valid,
  output logic [15:0]      out_stored_duration,
  output logic [4:0]       out_stored_count,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [dpdr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0] cfg_data
);

  dpdr_pkg::cfg_t      cfg_r;
  dpdr_pkg::res_t      core_res;
  dpdr_pkg::res_t      head;
  dpdr_pkg::store_wr_t store_wr;
  logic                q_full;
  logic                accept;

  // Configuration registers; a write to an index beyond the list is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_event_ms <= dpdr_pkg::MIN_EVENT_RST;
      cfg_r.max_press_ms <= dpdr_pkg::MAX_PRESS_RST;
      cfg_r.wait_ms      <= dpdr_pkg::WAIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dpdr_pkg::CFG_MIN_EVENT: cfg_r.min_event_ms <= cfg_data;
        dpdr_pkg::CFG_MAX_PRESS: cfg_r.max_press_ms <= cfg_data;
        dpdr_pkg::CFG_WAIT:      cfg_r.wait_ms      <= cfg_data;
        default: ;
      endcase
    end
  end

  // A word is taken whenever the output queue has room.
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  dpdr_core u_core (
    .clk (clk),
    .rst_n (rst_n),
    .acc (accept),
    .cmd (in_command),
    .raw (in_raw_level),
    .now (in_now_ms),
    .cfg (cfg_r),
    .res (core_res),
    .wr (store_wr)
  );

  dpdr_store u_store (
    .clk (clk),
    .wr (store_wr)
  );

  dpdr_out_fifo u_out_fifo (
    .clk (clk),
    .rst_n (rst_n),
    .push (accept),
    .push_data (core_res),
    .full (q_full),
    .pop (!out_stall),
    .not_empty (out_valid),
    .head (head)
  );

  assign out_smooth_level    = head.smooth_level;
  assign out_error_flag      = head.error_flag;
  assign out_finished_flag   = head.finished_flag;
  assign out_listening_flag  = head.listening_flag;
  assign out_stored_valid    = head.stored_valid;
  assign out_stored_duration = head.stored_duration;
  assign out_stored_count    = head.stored_count;

endmodule

`default_nettype wire
